FILE: src/time_weighted_bucket_resampler_top_defines.svh
// Assertion macros for the time-weighted bucket resampler checker.
`ifndef TIME_WEIGHTED_BUCKET_RESAMPLER_TOP_DEFINES_SVH
`define TIME_WEIGHTED_BUCKET_RESAMPLER_TOP_DEFINES_SVH
// Same-cycle implication, sampled on clk, off during reset.
`define TWBR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("twbr check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define TWBR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("twbr check failed");
`endif

FILE: src/twbr_pkg.sv
// Shared types and constants of the time-weighted bucket resampler.
`default_nettype none
package twbr_pkg;
	localparam int AXES = 3;
	localparam int VAL_W = 8;
	localparam int SEC_W = 32;
	localparam int US_W = 20;
	localparam int PW = 20;
	localparam int SUM_W = 28;
	localparam int RAW_W = 52;
	localparam int MAX_BUCKETS_DEFAULT = 64;
	localparam int QUEUE_DEPTH = 2;
	localparam int US_PER_SECOND = 1000000;
	localparam logic [PW-1:0] RESET_PERIOD_US = 20'd100000;

	typedef struct packed {
		logic [AXES-1:0][VAL_W-1:0] held;
		logic [AXES-1:0][VAL_W-1:0] cur;
		logic [RAW_W-1:0] dt;
		logic have;
		logic fin;
	} item_t;

	typedef struct packed {
		logic [AXES-1:0][VAL_W-1:0] mean;
		logic final_bkt;
		logic last;
		logic clamp;
	} res_t;
endpackage
`default_nettype wire

FILE: src/twbr_front.sv
// Front end: accepts samples, tracks the held timestamp, computes the interval.
`default_nettype none
module twbr_front import twbr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [AXES-1:0][VAL_W-1:0] cur,
	input  wire logic [SEC_W-1:0] sec,
	input  wire logic [US_W-1:0] us,
	input  wire logic fin,
	input  wire logic q_full,
	output logic q_push,
	output item_t q_item
);
	localparam int SD_W = SEC_W + 1;
	localparam int UD_W = US_W + 1;
	localparam int DS_W = RAW_W + 2;
	localparam logic signed [21:0] UsC = 22'(US_PER_SECOND);

	logic [AXES-1:0][VAL_W-1:0] held_q;
	logic [SEC_W-1:0] held_sec_q;
	logic [US_W-1:0] held_us_q;
	logic have_q;

	logic s1_valid_s1;
	logic [AXES-1:0][VAL_W-1:0] held_s1, cur_s1;
	logic signed [SD_W-1:0] sd_s1;
	logic signed [UD_W-1:0] ud_s1;
	logic have_s1, fin_s1;
	logic signed [DS_W-1:0] dt_s;
	logic accept;

	assign in_ready = !s1_valid_s1;
	assign accept = in_valid && in_ready;
	assign q_push = s1_valid_s1 && !q_full;

	always_comb begin
		// widen before the multiply so the seconds term keeps all its bits
		dt_s = DS_W'(sd_s1) * DS_W'(UsC) + DS_W'(ud_s1);
		q_item.held = held_s1;
		q_item.cur = cur_s1;
		q_item.dt = dt_s[DS_W-1] ? '0 : dt_s[RAW_W-1:0];
		q_item.have = have_s1;
		q_item.fin = fin_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			have_q <= 1'b0;
			held_sec_q <= '0;
			held_us_q <= '0;
			held_q <= '0;
		end else begin
			if (accept) begin
				s1_valid_s1 <= 1'b1;
				held_s1 <= held_q;
				cur_s1 <= cur;
				sd_s1 <= $signed({1'b0, sec}) - $signed({1'b0, held_sec_q});
				ud_s1 <= $signed({1'b0, us}) - $signed({1'b0, held_us_q});
				have_s1 <= have_q;
				fin_s1 <= fin;
				held_q <= cur;
				held_sec_q <= sec;
				held_us_q <= us;
				have_q <= !fin;
			end else if (q_push) begin
				s1_valid_s1 <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/twbr_queue.sv
// Short register queue between front and back end.
`default_nettype none
module twbr_queue import twbr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire item_t push_item,
	input  wire logic pop,
	output item_t pop_item,
	output logic full,
	output logic empty
);
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	item_t mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + CNT_W'(push && !full) - CNT_W'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

FILE: src/twbr_div.sv
// Three-lane bit-serial divider with truncation toward zero and 8-bit saturation.
`default_nettype none
module twbr_div import twbr_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [AXES-1:0][SUM_W-1:0] num,
	input  wire logic [PW-1:0] den,
	output logic done,
	output logic [AXES-1:0][VAL_W-1:0] quo
);
	localparam int CW = $clog2(SUM_W);

	logic [AXES-1:0][SUM_W-1:0] mag_q, mag_n;
	logic [AXES-1:0][PW-1:0] rem_q, rem_n;
	logic [AXES-1:0] neg_q;
	logic [PW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic [PW:0] trial;
	logic ge;

	function automatic logic [VAL_W-1:0] sat(input logic [SUM_W-1:0] m, input logic n);
		logic [VAL_W-1:0] r;
		if (n) r = (m > SUM_W'(128)) ? 8'h80 : 8'(~m[VAL_W-1:0] + 1'b1);
		else r = (m > SUM_W'(127)) ? 8'h7f : m[VAL_W-1:0];
		return r;
	endfunction

	always_comb begin
		trial = '0;
		ge = 1'b0;
		for (int i = 0; i < AXES; i++) begin
			trial = {rem_q[i], mag_q[i][SUM_W-1]};
			ge = trial >= {1'b0, den_q};
			rem_n[i] = ge ? PW'(trial - {1'b0, den_q}) : trial[PW-1:0];
			mag_n[i] = {mag_q[i][SUM_W-2:0], ge};
			quo[i] = sat(mag_q[i], neg_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
				den_q <= den;
				for (int i = 0; i < AXES; i++) begin
					neg_q[i] <= num[i][SUM_W-1];
					mag_q[i] <= num[i][SUM_W-1] ? SUM_W'(-$signed(num[i])) : num[i];
					rem_q[i] <= '0;
				end
			end else if (busy_q) begin
				mag_q <= mag_n;
				rem_q <= rem_n;
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

FILE: src/twbr_back.sv
// Back end: bucket accumulation, closing, clamping and flush sequencer.
`default_nettype none
module twbr_back import twbr_pkg::*; #(
	parameter int MAX_BUCKETS_PER_ITEM = MAX_BUCKETS_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic [PW-1:0] period,
	input  wire logic q_empty,
	input  wire item_t q_item,
	output logic q_pop,
	output logic out_valid,
	input  wire logic out_ready,
	output res_t res
);
	localparam int LIMIT = MAX_BUCKETS_PER_ITEM - 1;
	localparam int DT_W = PW + $clog2(MAX_BUCKETS_PER_ITEM) + 1;

	typedef enum logic [2:0] {ST_IDLE, ST_PREP, ST_LOOP, ST_PAD, ST_DIV, ST_OUT} state_t;
	state_t state_q;

	item_t item_q;
	logic [PW-1:0] tm_q, filled_q;
	logic [DT_W-1:0] dt_q;
	logic [AXES-1:0][SUM_W-1:0] sum_q, num_q, mac;
	logic clamp_q, fin_bkt_q, last_q, div_start_q;

	logic [PW-1:0] miss, mul_b;
	logic [RAW_W-1:0] dt_eff, gap;
	logic [DT_W-1:0] lim_p, dt_left;
	logic clamp_c, close_c;
	logic div_done;
	logic [AXES-1:0][VAL_W-1:0] quo;
	logic [AXES-1:0][VAL_W-1:0] mul_a;

	assign q_pop = (state_q == ST_IDLE) && !q_empty;

	always_comb begin
		miss = (filled_q >= period) ? '0 : period - filled_q;
		dt_eff = item_q.have ? item_q.dt : '0;
		lim_p = DT_W'(DT_W'(period) * DT_W'(LIMIT));
		gap = dt_eff - RAW_W'(miss);
		clamp_c = (dt_eff > RAW_W'(miss)) && (gap > RAW_W'(lim_p));
		close_c = DT_W'(tm_q) < dt_q;
		dt_left = dt_q - DT_W'(tm_q);
		// one multiplier per axis: held*tm on close, held*dt on tail, new*missing on pad
		mul_a = (state_q == ST_PAD) ? item_q.cur : item_q.held;
		if (state_q == ST_PAD) mul_b = miss;
		else if (close_c) mul_b = tm_q;
		else mul_b = dt_q[PW-1:0];
		for (int i = 0; i < AXES; i++) begin
			mac[i] = SUM_W'($signed(sum_q[i]) + $signed(mul_a[i]) * $signed({1'b0, mul_b}));
		end
	end

	twbr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start_q),
		.num(num_q),
		.den(period),
		.done(div_done),
		.quo(quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q <= '0;
			filled_q <= '0;
			out_valid <= 1'b0;
			div_start_q <= 1'b0;
			clamp_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						item_q <= q_item;
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					tm_q <= miss;
					clamp_q <= clamp_c;
					dt_q <= clamp_c ? DT_W'(miss) + lim_p : dt_eff[DT_W-1:0];
					state_q <= ST_LOOP;
				end
				ST_LOOP: begin
					if (close_c) begin
						num_q <= mac;
						sum_q <= '0;
						filled_q <= '0;
						dt_q <= dt_left;
						tm_q <= period;
						fin_bkt_q <= 1'b0;
						last_q <= !(DT_W'(period) < dt_left) && !item_q.fin;
						div_start_q <= 1'b1;
						state_q <= ST_DIV;
					end else begin
						sum_q <= mac;
						filled_q <= filled_q + dt_q[PW-1:0];
						state_q <= item_q.fin ? ST_PAD : ST_IDLE;
					end
				end
				ST_PAD: begin
					num_q <= mac;
					sum_q <= '0;
					filled_q <= '0;
					fin_bkt_q <= 1'b1;
					last_q <= 1'b1;
					div_start_q <= 1'b1;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						res.mean <= quo;
						res.final_bkt <= fin_bkt_q;
						res.last <= last_q;
						res.clamp <= clamp_q;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= fin_bkt_q ? ST_IDLE : ST_LOOP;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/time_weighted_bucket_resampler_top.sv
// Top level of the time-weighted bucket resampler.
// Usage:
//  - Input channel (in_valid/in_ready): one beat is one timestamped 3-axis
//    sample. The first sample after reset or after a capture end is only held.
//  - Output channel (out_valid/out_ready): one beat per closed bucket, the
//    time-weighted mean of each axis, truncated toward zero, saturated to 8 bits.
//    last_of_run marks the last bucket of a sample, final_bucket the padded
//    flush bucket of a capture_end sample, gap_clamped a clipped long interval.
//  - cfg_we/cfg_wdata write the bucket period in us (0 acts as 1); write idle.
// Timing:
//  - Front end holds one sample at a time (in_ready is low while it does) and
//    pushes it into a 2-entry queue. Back end: one sample at a time; each emitted
//    bucket goes through the 28-step bit-serial divider (one bit per cycle).
// Stall: while out_ready is low the bucket holds on the port and the back end
//  waits; the queue keeps taking samples until it fills, then in_ready drops.
// Reset: arst_n clears held sample and bucket sums and sets the period to 100000 us.
`default_nettype none
module time_weighted_bucket_resampler_top import twbr_pkg::*; #(
	parameter int MAX_BUCKETS_PER_ITEM = MAX_BUCKETS_DEFAULT
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic [PW-1:0] cfg_wdata,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic signed [VAL_W-1:0] sample_x,
	input  wire logic signed [VAL_W-1:0] sample_y,
	input  wire logic signed [VAL_W-1:0] sample_z,
	input  wire logic [SEC_W-1:0] stamp_seconds,
	input  wire logic [US_W-1:0] stamp_micros,
	input  wire logic capture_end,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [VAL_W-1:0] mean_x,
	output logic signed [VAL_W-1:0] mean_y,
	output logic signed [VAL_W-1:0] mean_z,
	output logic final_bucket,
	output logic last_of_run,
	output logic gap_clamped
);
	logic [PW-1:0] period_q, period_eff;
	logic q_full, q_empty, q_push, q_pop;
	item_t push_item, pop_item;
	res_t res;

	// bucket period register; zero behaves as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) period_q <= RESET_PERIOD_US;
		else if (cfg_we) period_q <= cfg_wdata;
	end
	assign period_eff = (period_q == '0) ? PW'(1) : period_q;

	twbr_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cur({sample_z, sample_y, sample_x}),
		.sec(stamp_seconds),
		.us(stamp_micros),
		.fin(capture_end),
		.q_full(q_full),
		.q_push(q_push),
		.q_item(push_item)
	);

	twbr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_item(push_item),
		.pop(q_pop),
		.pop_item(pop_item),
		.full(q_full),
		.empty(q_empty)
	);

	twbr_back #(.MAX_BUCKETS_PER_ITEM(MAX_BUCKETS_PER_ITEM)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.period(period_eff),
		.q_empty(q_empty),
		.q_item(pop_item),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.res(res)
	);

	assign mean_x = res.mean[0];
	assign mean_y = res.mean[1];
	assign mean_z = res.mean[2];
	assign final_bucket = res.final_bkt;
	assign last_of_run = res.last;
	assign gap_clamped = res.clamp;
endmodule
`default_nettype wire

FILE: src/twbr_checker.sv
// Port-level checker for the resampler, bound to the top level.
`default_nettype none
`include "time_weighted_bucket_resampler_top_defines.svh"
module twbr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [7:0] mean_x,
	input wire logic [7:0] mean_y,
	input wire logic [7:0] mean_z,
	input wire logic final_bucket,
	input wire logic last_of_run,
	input wire logic gap_clamped
);
	`TWBR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({mean_x, mean_y, mean_z, final_bucket, last_of_run, gap_clamped}))
	`TWBR_ASSERT_NOW(a_final_is_last, out_valid && final_bucket, last_of_run)
	`TWBR_ASSERT_NEXT(a_gap_after_beat, out_valid && out_ready, !out_valid)
endmodule
bind time_weighted_bucket_resampler_top twbr_checker u_twbr_checker (.*);
`default_nettype wire
